// ----- hdl/msc_pkg.sv -----
// ----------------------------------------------------------------------------
// msc_pkg: shared types and constants of the mouse delta scaler
// Field widths, register indexes, configuration and command/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package msc_pkg;

	// Field widths
	localparam int MAG_W   = 16;   // magnitude of a 16 bit signed delta
	localparam int SCALE_W = 10;
	localparam int SENS_W  = 16;
	localparam int GAIN_W  = 18;
	localparam int THR_W   = 16;
	localparam int BTN_W   = 8;
	localparam int OUT_W   = 32;
	localparam int LO_W    = 17;

	// Intermediate widths of the magnitude path
	localparam int P1_W       = MAG_W + SCALE_W;      // delta * game scale
	localparam int P2_W       = P1_W + SENS_W;        // * sensitivity
	localparam int Q_W        = 27;                   // quotient by the unity constant
	localparam int P3_W       = Q_W + GAIN_W;         // * axis gain
	localparam int GAIN_SHIFT = 16;                   // / 65536
	localparam int SUM_W      = 32;                   // signed axis values
	localparam int SAT_IN_W   = SUM_W + 1;

	// Divider widths
	localparam int DIV_NUM_W = P2_W;
	localparam int DIV_DEN_W = 16;

	// Sensitivity unity divisor
	localparam logic [DIV_DEN_W-1:0] SENS_UNITY = 16'd32792;

	// Configuration port
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	typedef enum logic [2:0] {
		REG_SCALE_X     = 3'd0,
		REG_SCALE_Y     = 3'd1,
		REG_SENSITIVITY = 3'd2,
		REG_GAIN_X      = 3'd3,
		REG_GAIN_Y      = 3'd4,
		REG_Y_THRESHOLD = 3'd5,
		REG_INVERT_Y    = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [SCALE_W-1:0] scale_x;
		logic [SCALE_W-1:0] scale_y;
		logic [SENS_W-1:0]  sensitivity;
		logic [GAIN_W-1:0]  gain_x;
		logic [GAIN_W-1:0]  gain_y;
		logic [THR_W-1:0]   y_threshold;
		logic               invert_y;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		scale_x:     10'd32,
		scale_y:     10'd48,
		sensitivity: 16'd32792,
		gain_x:      18'd65536,
		gain_y:      18'd65536,
		y_threshold: 16'd1,
		invert_y:    1'b0
	};

	// Divider operand select
	typedef enum logic [1:0] {
		DIV_X   = 2'd0,
		DIV_Y   = 2'd1,
		DIV_MOD = 2'd2
	} div_sel_t;

	// Controller to datapath commands
	typedef struct packed {
		logic     capture;
		logic     mul1;
		logic     mul2;
		logic     div_start;
		div_sel_t div_sel;
		logic     take_qx;
		logic     take_qy;
		logic     mul3;
		logic     sum;
		logic     take_rem;
		logic     load_out;
	} ctrl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic div_busy;
		logic div_done;
		logic out_free;
	} dp_status_t;

	localparam logic signed [SAT_IN_W-1:0] SAT_MAX = 33'sh0_7FFF_FFFF;
	localparam logic signed [SAT_IN_W-1:0] SAT_MIN = 33'sh1_8000_0000;

	// Clamp a signed value to the 32 bit output range
	function automatic logic signed [OUT_W-1:0] sat32(input logic signed [SAT_IN_W-1:0] v);
		logic signed [OUT_W-1:0] r;
		if (v > SAT_MAX) begin
			r = SAT_MAX[OUT_W-1:0];
		end else if (v < SAT_MIN) begin
			r = SAT_MIN[OUT_W-1:0];
		end else begin
			r = v[OUT_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/msc_div.sv -----
// ----------------------------------------------------------------------------
// msc_div: iterative unsigned divider
// Restoring division, two quotient bits per cycle; gives quotient and remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module msc_div (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic [msc_pkg::DIV_NUM_W-1:0]   num,
	input  wire logic [msc_pkg::DIV_DEN_W-1:0]   den,
	output logic                                 busy,
	output logic                                 done,
	output logic [msc_pkg::DIV_NUM_W-1:0]        quo,
	output logic [msc_pkg::DIV_DEN_W-1:0]        rem
);

	localparam int NUM_W = msc_pkg::DIV_NUM_W;
	localparam int DEN_W = msc_pkg::DIV_DEN_W;
	localparam int STEPS = NUM_W / 2;
	localparam int CNT_W = $clog2(STEPS);

	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DEN_W:0]   t0, t1;
	logic [DEN_W-1:0] r0, r1;
	logic             b0, b1;

	// Two restoring steps
	always_comb begin
		t0 = {rem_q, quo_q[NUM_W-1]};
		b0 = (t0 >= {1'b0, den_q});
		r0 = b0 ? DEN_W'(t0 - {1'b0, den_q}) : t0[DEN_W-1:0];
		t1 = {r0, quo_q[NUM_W-2]};
		b1 = (t1 >= {1'b0, den_q});
		r1 = b1 ? DEN_W'(t1 - {1'b0, den_q}) : t1[DEN_W-1:0];
	end

	// Sequence the iterations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(STEPS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Shift quotient bits in, hold the partial remainder
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-3:0], b0, b1};
			rem_q <= r1;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

// ----- hdl/msc_ctrl.sv -----
// ----------------------------------------------------------------------------
// msc_ctrl: sequencer of the mouse delta scaler
// Steps one report through multiply, divide, remainder and output load.
// ----------------------------------------------------------------------------
`default_nettype none

module msc_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire msc_pkg::dp_status_t   status,
	output msc_pkg::ctrl_cmd_t         cmd,
	output logic                       in_stall
);

	typedef enum logic [11:0] {
		S_IDLE = 12'b0000_0000_0001,
		S_MUL1 = 12'b0000_0000_0010,
		S_MUL2 = 12'b0000_0000_0100,
		S_XGO  = 12'b0000_0000_1000,
		S_XRUN = 12'b0000_0001_0000,
		S_YGO  = 12'b0000_0010_0000,
		S_YRUN = 12'b0000_0100_0000,
		S_MUL3 = 12'b0000_1000_0000,
		S_SUM  = 12'b0001_0000_0000,
		S_MGO  = 12'b0010_0000_0000,
		S_MRUN = 12'b0100_0000_0000,
		S_DONE = 12'b1000_0000_0000
	} state_t;

	state_t state_q, state_d;

	// Next state and commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_MUL1;
				end
			end
			S_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = S_XGO;
			end
			S_XGO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = msc_pkg::DIV_X;
				state_d       = S_XRUN;
			end
			S_XRUN: begin
				if (status.div_done) begin
					cmd.take_qx = 1'b1;
					state_d     = S_YGO;
				end
			end
			S_YGO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = msc_pkg::DIV_Y;
				state_d       = S_YRUN;
			end
			S_YRUN: begin
				if (status.div_done) begin
					cmd.take_qy = 1'b1;
					state_d     = S_MUL3;
				end
			end
			S_MUL3: begin
				cmd.mul3 = 1'b1;
				state_d  = S_SUM;
			end
			S_SUM: begin
				cmd.sum = 1'b1;
				state_d = S_MGO;
			end
			S_MGO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = msc_pkg::DIV_MOD;
				state_d       = S_MRUN;
			end
			S_MRUN: begin
				if (status.div_done) begin
					cmd.take_rem = 1'b1;
					state_d      = S_DONE;
				end
			end
			S_DONE: begin
				// Wait for room in the output register
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);

endmodule

`default_nettype wire

// ----- hdl/msc_dp.sv -----
// ----------------------------------------------------------------------------
// msc_dp: datapath of the mouse delta scaler
// Sign-magnitude scaling of both axes, vertical leftover and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module msc_dp (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire msc_pkg::ctrl_cmd_t                  cmd,
	input  wire msc_pkg::cfg_t                       cfg,
	input  wire logic signed [msc_pkg::MAG_W-1:0]    delta_x,
	input  wire logic signed [msc_pkg::MAG_W-1:0]    delta_y,
	input  wire logic [msc_pkg::BTN_W-1:0]           button_bits,
	input  wire logic                                out_stall,
	output msc_pkg::dp_status_t                      status,
	output logic                                     out_valid,
	output logic signed [msc_pkg::OUT_W-1:0]         axis_x,
	output logic signed [msc_pkg::OUT_W-1:0]         axis_y,
	output logic [msc_pkg::BTN_W-1:0]                button_state
);

	localparam int MAG_W     = msc_pkg::MAG_W;
	localparam int P1_W      = msc_pkg::P1_W;
	localparam int P2_W      = msc_pkg::P2_W;
	localparam int Q_W       = msc_pkg::Q_W;
	localparam int P3_W      = msc_pkg::P3_W;
	localparam int SUM_W     = msc_pkg::SUM_W;
	localparam int LO_W      = msc_pkg::LO_W;
	localparam int NUM_W     = msc_pkg::DIV_NUM_W;
	localparam int DEN_W     = msc_pkg::DIV_DEN_W;
	localparam int SHIFT     = msc_pkg::GAIN_SHIFT;
	localparam int SAT_IN_W  = msc_pkg::SAT_IN_W;

	logic                        sgn_x_q, sgn_y_q;
	logic [MAG_W-1:0]            mag_x_q, mag_y_q;
	logic [msc_pkg::BTN_W-1:0]   btn_q;
	logic [P1_W-1:0]             p1_x_q, p1_y_q;
	logic [P2_W-1:0]             p2_x_q, p2_y_q;
	logic [Q_W-1:0]              qx_q, qy_q;
	logic [P3_W-1:0]             p3_x_q, p3_y_q;
	logic [SUM_W-1:0]            ax_q, ysum_q;
	logic [LO_W-1:0]             lo_q;
	logic                        out_valid_q;
	logic signed [msc_pkg::OUT_W-1:0] axis_x_q, axis_y_q;
	logic [msc_pkg::BTN_W-1:0]   btn_out_q;

	logic [MAG_W-1:0]            mag_x_d, mag_y_d;
	logic [SUM_W-1:0]            ax_mag, ay_mag, ax_val, ay_val, ysum_mag;
	logic [NUM_W-1:0]            div_num;
	logic [DEN_W-1:0]            div_den;
	logic                        div_busy, div_done;
	logic [NUM_W-1:0]            div_quo;
	logic [DEN_W-1:0]            div_rem;
	logic [LO_W-1:0]             rem_ext, lo_d;
	logic signed [SAT_IN_W-1:0]  x_wide, y_wide;

	// Split the deltas into sign and magnitude
	always_comb begin
		mag_x_d = delta_x[MAG_W-1] ? (~delta_x + 1'b1) : delta_x;
		mag_y_d = delta_y[MAG_W-1] ? (~delta_y + 1'b1) : delta_y;
	end

	// Select divider operands
	always_comb begin
		ysum_mag = ysum_q[SUM_W-1] ? (~ysum_q + 1'b1) : ysum_q;
		case (cmd.div_sel)
			msc_pkg::DIV_X: begin
				div_num = p2_x_q;
				div_den = msc_pkg::SENS_UNITY;
			end
			msc_pkg::DIV_Y: begin
				div_num = p2_y_q;
				div_den = msc_pkg::SENS_UNITY;
			end
			msc_pkg::DIV_MOD: begin
				div_num = NUM_W'(ysum_mag);
				div_den = cfg.y_threshold;
			end
			default: begin
				div_num = p2_x_q;
				div_den = msc_pkg::SENS_UNITY;
			end
		endcase
	end

	msc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	// Drop the gain fraction and restore the sign
	always_comb begin
		ax_mag = SUM_W'(p3_x_q[P3_W-1:SHIFT]);
		ay_mag = SUM_W'(p3_y_q[P3_W-1:SHIFT]);
		ax_val = sgn_x_q ? (~ax_mag + 1'b1) : ax_mag;
		ay_val = sgn_y_q ? (~ay_mag + 1'b1) : ay_mag;
	end

	// New leftover: remainder with the sign of the vertical sum, zero when y_threshold is zero
	always_comb begin
		rem_ext = {1'b0, div_rem};
		if (cfg.y_threshold == '0) begin
			lo_d = '0;
		end else if (ysum_q[SUM_W-1]) begin
			lo_d = ~rem_ext + 1'b1;
		end else begin
			lo_d = rem_ext;
		end
	end

	// Widen and invert the outputs ahead of the clamp at the output load
	always_comb begin
		x_wide = {ax_q[SUM_W-1], ax_q};
		if (cfg.invert_y) begin
			y_wide = SAT_IN_W'(0) - {ysum_q[SUM_W-1], ysum_q};
		end else begin
			y_wide = {ysum_q[SUM_W-1], ysum_q};
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sgn_x_q <= delta_x[MAG_W-1];
			sgn_y_q <= delta_y[MAG_W-1];
			mag_x_q <= mag_x_d;
			mag_y_q <= mag_y_d;
			btn_q   <= button_bits;
		end
		if (cmd.mul1) begin
			p1_x_q <= P1_W'(mag_x_q) * P1_W'(cfg.scale_x);
			p1_y_q <= P1_W'(mag_y_q) * P1_W'(cfg.scale_y);
		end
		if (cmd.mul2) begin
			p2_x_q <= P2_W'(p1_x_q) * P2_W'(cfg.sensitivity);
			p2_y_q <= P2_W'(p1_y_q) * P2_W'(cfg.sensitivity);
		end
		if (cmd.take_qx) begin
			qx_q <= div_quo[Q_W-1:0];
		end
		if (cmd.take_qy) begin
			qy_q <= div_quo[Q_W-1:0];
		end
		if (cmd.mul3) begin
			p3_x_q <= P3_W'(qx_q) * P3_W'(cfg.gain_x);
			p3_y_q <= P3_W'(qy_q) * P3_W'(cfg.gain_y);
		end
		if (cmd.sum) begin
			ax_q   <= ax_val;
			ysum_q <= ay_val + {{(SUM_W-LO_W){lo_q[LO_W-1]}}, lo_q};
		end
		if (cmd.load_out) begin
			axis_x_q  <= msc_pkg::sat32(x_wide);
			axis_y_q  <= msc_pkg::sat32(y_wide);
			btn_out_q <= btn_q;
		end
	end

	// Leftover state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.take_rem) begin
				lo_q <= lo_d;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.div_busy = div_busy;
	assign status.div_done = div_done;
	assign status.out_free = !out_valid_q || !out_stall;

	assign out_valid    = out_valid_q;
	assign axis_x       = axis_x_q;
	assign axis_y       = axis_y_q;
	assign button_state = btn_out_q;

endmodule

`default_nettype wire

// ----- hdl/mouse_delta_scaler.sv -----
// ----------------------------------------------------------------------------
// mouse_delta_scaler: scales raw mouse reports into axis values
// Input channel: delta_x, delta_y, button_bits with in_valid / in_stall.
// Output channel: axis_x, axis_y, button_state with out_valid / out_stall.
// Both axes are multiplied by game scale and sensitivity, divided by the
// sensitivity unity 32792, multiplied by the axis gain and divided by 65536,
// each step truncating toward zero. Y adds the stored leftover, keeps the new
// leftover modulo y_threshold, and is negated when invert_y is set.
// A new report is taken only after the previous result has been loaded into
// the output register; each report makes three passes through the shared
// divider, which produces two quotient bits a cycle.
// in_stall is low only while the sequencer is idle; the next report is taken
// while the previous result still waits in the output register.
// If the receiver stalls, the result holds and the sequencer waits at its end
// until the output register is free.
// Reset loads the register defaults and clears the leftover and all valids.
// Registers sit on an APB-style port at byte address 4*index; pready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module mouse_delta_scaler (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// Input channel
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic signed [msc_pkg::MAG_W-1:0]    delta_x,
	input  wire logic signed [msc_pkg::MAG_W-1:0]    delta_y,
	input  wire logic [msc_pkg::BTN_W-1:0]           button_bits,
	// Output channel
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic signed [msc_pkg::OUT_W-1:0]         axis_x,
	output logic signed [msc_pkg::OUT_W-1:0]         axis_y,
	output logic [msc_pkg::BTN_W-1:0]                button_state,
	// Configuration port
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [msc_pkg::ADDR_W-1:0]          paddr,
	input  wire logic [msc_pkg::DATA_W-1:0]          pwdata,
	output logic [msc_pkg::DATA_W-1:0]               prdata,
	output logic                                     pready
);

	localparam int DATA_W = msc_pkg::DATA_W;
	localparam int ADDR_W = msc_pkg::ADDR_W;

	msc_pkg::cfg_t       cfg_q;
	msc_pkg::ctrl_cmd_t  cmd;
	msc_pkg::dp_status_t st;
	msc_pkg::reg_idx_t   reg_idx;

	assign reg_idx = msc_pkg::reg_idx_t'(paddr[ADDR_W-1:2]);
	assign pready  = 1'b1;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= msc_pkg::CFG_RESET;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				msc_pkg::REG_SCALE_X:     cfg_q.scale_x     <= pwdata[msc_pkg::SCALE_W-1:0];
				msc_pkg::REG_SCALE_Y:     cfg_q.scale_y     <= pwdata[msc_pkg::SCALE_W-1:0];
				msc_pkg::REG_SENSITIVITY: cfg_q.sensitivity <= pwdata[msc_pkg::SENS_W-1:0];
				msc_pkg::REG_GAIN_X:      cfg_q.gain_x      <= pwdata[msc_pkg::GAIN_W-1:0];
				msc_pkg::REG_GAIN_Y:      cfg_q.gain_y      <= pwdata[msc_pkg::GAIN_W-1:0];
				msc_pkg::REG_Y_THRESHOLD: cfg_q.y_threshold <= pwdata[msc_pkg::THR_W-1:0];
				msc_pkg::REG_INVERT_Y:    cfg_q.invert_y    <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	// Register reads
	always_comb begin
		case (reg_idx)
			msc_pkg::REG_SCALE_X:     prdata = DATA_W'(cfg_q.scale_x);
			msc_pkg::REG_SCALE_Y:     prdata = DATA_W'(cfg_q.scale_y);
			msc_pkg::REG_SENSITIVITY: prdata = DATA_W'(cfg_q.sensitivity);
			msc_pkg::REG_GAIN_X:      prdata = DATA_W'(cfg_q.gain_x);
			msc_pkg::REG_GAIN_Y:      prdata = DATA_W'(cfg_q.gain_y);
			msc_pkg::REG_Y_THRESHOLD: prdata = DATA_W'(cfg_q.y_threshold);
			msc_pkg::REG_INVERT_Y:    prdata = DATA_W'(cfg_q.invert_y);
			default:                  prdata = '0;
		endcase
	end

	msc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.status   (st),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	msc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cfg          (cfg_q),
		.delta_x      (delta_x),
		.delta_y      (delta_y),
		.button_bits  (button_bits),
		.out_stall    (out_stall),
		.status       (st),
		.out_valid    (out_valid),
		.axis_x       (axis_x),
		.axis_y       (axis_y),
		.button_state (button_state)
	);

	// A freshly taken report cannot produce a result on the next cycle
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> !$rose(out_valid))
		else $error("result appeared right after a report was taken");

	// Load the output register only when it is free
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid || !out_stall))
		else $error("output register overwritten while stalled");

	// Never restart the divider mid-run
	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !st.div_busy)
		else $error("divider started while busy");

	// Hold off new reports while a division runs
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		st.div_busy |-> in_stall)
		else $error("input not stalled during division");

endmodule

`default_nettype wire

// ----- tb/tb_mouse_delta_scaler.sv -----
// ----------------------------------------------------------------------------
// tb_mouse_delta_scaler: self-checking bench for the mouse delta scaler
// Drives corner reports and random bursts of mouse reports against a receiver that stalls on its
// own pattern, predicts every scaled report (including the carried vertical
// leftover) and compares each output beat field by field.
// ----------------------------------------------------------------------------

module tb_mouse_delta_scaler;

	timeunit 1ns;
	timeprecision 1ps;

	import msc_pkg::*;

	localparam int     LIMIT_CYCLES  = 1000000;
	localparam int     TAIL_CYCLES   = 120;
	localparam int     PRESSURE_HOLD = 600;
	localparam int     RANDOM_PHASES = 6;
	localparam int     PHASE_ITEMS   = 80;
	localparam longint SENS_DIV      = 32792;
	localparam longint GAIN_DIV      = 65536;
	localparam longint OUT_MAX       = 64'sd2147483647;
	localparam longint OUT_MIN       = -64'sd2147483648;
	// Index past the register map: writes there must be ignored
	localparam logic [2:0] REG_UNMAPPED = 3'd7;

	// Corner reports used in each directed phase
	localparam logic signed [15:0] EDGE_DX [8] = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0001,
		16'shFFFF, 16'sd12345, -16'sd7, 16'sh7FFF};
	localparam logic signed [15:0] EDGE_DY [8] = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF,
		16'sh0001, -16'sd23456, 16'sd13, 16'sh7FFF};
	localparam logic [7:0] EDGE_BTN [8] = '{8'hFF, 8'h00, 8'hA5, 8'h5A, 8'h01, 8'h80, 8'h7F,
		8'hFF};

	typedef struct {
		logic signed [OUT_W-1:0] axis_x;
		logic signed [OUT_W-1:0] axis_y;
		logic [BTN_W-1:0]        buttons;
	} scaled_report_t;

	// Scaler shadow: register copy, vertical leftover and queued reports
	class scaled_report_check;
		logic [SCALE_W-1:0]     scale_x;
		logic [SCALE_W-1:0]     scale_y;
		logic [SENS_W-1:0]      sensitivity;
		logic [GAIN_W-1:0]      gain_x;
		logic [GAIN_W-1:0]      gain_y;
		logic [THR_W-1:0]       y_threshold;
		logic                   invert_y;
		logic signed [LO_W-1:0] leftover_y;
		scaled_report_t         pending_reports[$];
		int                     errors;

		function new();
			scale_x     = CFG_RESET.scale_x;
			scale_y     = CFG_RESET.scale_y;
			sensitivity = CFG_RESET.sensitivity;
			gain_x      = CFG_RESET.gain_x;
			gain_y      = CFG_RESET.gain_y;
			y_threshold = CFG_RESET.y_threshold;
			invert_y    = CFG_RESET.invert_y;
			leftover_y  = '0;
			errors      = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [DATA_W-1:0] data);
			case (idx)
				REG_SCALE_X:     scale_x = data[SCALE_W-1:0];
				REG_SCALE_Y:     scale_y = data[SCALE_W-1:0];
				REG_SENSITIVITY: sensitivity = data[SENS_W-1:0];
				REG_GAIN_X:      gain_x = data[GAIN_W-1:0];
				REG_GAIN_Y:      gain_y = data[GAIN_W-1:0];
				REG_Y_THRESHOLD: y_threshold = data[THR_W-1:0];
				REG_INVERT_Y:    invert_y = data[0];
				default: ;
			endcase
		endfunction

		function longint scale_axis(longint d, longint game, longint gain);
			longint v;
			v = d * game;
			v = v * longint'(sensitivity);
			v = v / SENS_DIV;
			v = v * gain;
			v = v / GAIN_DIV;
			return v;
		endfunction

		function logic signed [OUT_W-1:0] clamp_out(longint v);
			if (v > OUT_MAX) v = OUT_MAX;
			if (v < OUT_MIN) v = OUT_MIN;
			return v[OUT_W-1:0];
		endfunction

		// Predict one accepted report and queue it
		function void take_report(logic signed [MAG_W-1:0] dx, logic signed [MAG_W-1:0] dy,
				logic [BTN_W-1:0] btn);
			scaled_report_t r;
			longint ax;
			longint ay;
			longint rem;
			ax  = scale_axis(longint'(dx), longint'(scale_x), longint'(gain_x));
			ay  = scale_axis(longint'(dy), longint'(scale_y), longint'(gain_y));
			ay  = ay + longint'(leftover_y);
			// carry the remainder of the sum, before inversion; zero modulus drops it
			rem = 0;
			if (y_threshold != 0) rem = ay % longint'(y_threshold);
			leftover_y = rem[LO_W-1:0];
			if (invert_y) ay = -ay;
			r.axis_x  = clamp_out(ax);
			r.axis_y  = clamp_out(ay);
			r.buttons = btn;
			pending_reports.push_back(r);
		endfunction

		// Compare one output beat against the oldest prediction
		function void check_report(logic signed [OUT_W-1:0] ax, logic signed [OUT_W-1:0] ay,
				logic [BTN_W-1:0] btn);
			scaled_report_t e;
			if (pending_reports.size() == 0) begin
				$error("output beat with no report pending: axis_x %0d axis_y %0d", ax, ay);
				errors++;
				return;
			end
			e = pending_reports.pop_front();
			if (ax !== e.axis_x) begin
				$error("axis_x: expected %0d, got %0d", e.axis_x, ax);
				errors++;
			end
			if (ay !== e.axis_y) begin
				$error("axis_y: expected %0d, got %0d", e.axis_y, ay);
				errors++;
			end
			if (btn !== e.buttons) begin
				$error("button_state: expected %0h, got %0h", e.buttons, btn);
				errors++;
			end
		endfunction

		function int pending();
			return pending_reports.size();
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic signed [MAG_W-1:0]  delta_x = '0;
	logic signed [MAG_W-1:0]  delta_y = '0;
	logic [BTN_W-1:0]         button_bits = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic signed [OUT_W-1:0]  axis_x;
	logic signed [OUT_W-1:0]  axis_y;
	logic [BTN_W-1:0]         button_state;
	logic                     psel = 1'b0;
	logic                     penable = 1'b0;
	logic                     pwrite = 1'b0;
	logic [ADDR_W-1:0]        paddr = '0;
	logic [DATA_W-1:0]        pwdata = '0;
	logic [DATA_W-1:0]        prdata;
	logic                     pready;

	scaled_report_check sb = new();
	int cycle_count   = 0;
	int reports_sent  = 0;
	int results_seen  = 0;
	int setting_count = 1;

	mouse_delta_scaler dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.delta_x      (delta_x),
		.delta_y      (delta_y),
		.button_bits  (button_bits),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.axis_x       (axis_x),
		.axis_y       (axis_y),
		.button_state (button_state),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Stop a hung run
	initial begin
		wait (cycle_count >= LIMIT_CYCLES);
		$display("timeout after %0d cycles, %0d reports still pending", cycle_count,
			sb.pending());
		$display("end of test: mismatches");
		$finish;
	end

	// Check every output beat
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sb.check_report(axis_x, axis_y, button_state);
			results_seen <= results_seen + 1;
		end
	end

	// Stall the output on a pattern of its own, with one long hold-off
	initial begin
		int  mode;
		int  n;
		bit  pressure_done;
		pressure_done = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!pressure_done && results_seen >= 40) begin
				pressure_done = 1'b1;
				out_stall <= 1'b1;
				repeat (PRESSURE_HOLD) @(posedge clk);
			end else begin
				mode = $urandom_range(0, 2);
				n    = (mode == 2) ? $urandom_range(1, 30) : $urandom_range(1, 200);
				repeat (n) begin
					case (mode)
						0: out_stall <= 1'b0;
						1: out_stall <= $urandom_range(0, 1);
						default: out_stall <= 1'b1;
					endcase
					@(posedge clk);
				end
			end
		end
	end

	// Offer one report and hold it until taken
	task automatic offer_report(logic signed [MAG_W-1:0] dx, logic signed [MAG_W-1:0] dy,
			logic [BTN_W-1:0] btn);
		delta_x     <= dx;
		delta_y     <= dy;
		button_bits <= btn;
		in_valid    <= 1'b1;
		do @(posedge clk); while (in_stall);
		sb.take_report(dx, dy, btn);
		reports_sent++;
	endtask

	task automatic idle_input(int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Drop valid and wait until every queued report has come out
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic apb_write(logic [2:0] idx, logic [DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, data);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_all(logic [DATA_W-1:0] sx, logic [DATA_W-1:0] sy,
			logic [DATA_W-1:0] sens, logic [DATA_W-1:0] gx, logic [DATA_W-1:0] gy,
			logic [DATA_W-1:0] thr, logic [DATA_W-1:0] inv);
		apb_write(REG_SCALE_X, sx);
		apb_write(REG_SCALE_Y, sy);
		apb_write(REG_SENSITIVITY, sens);
		apb_write(REG_GAIN_X, gx);
		apb_write(REG_GAIN_Y, gy);
		apb_write(REG_Y_THRESHOLD, thr);
		apb_write(REG_INVERT_Y, inv);
		// must leave every register untouched
		apb_write(REG_UNMAPPED, $urandom);
		setting_count++;
	endtask

	// Pick a register value: zero, full scale, unity-like or random upper bits too
	function automatic logic [DATA_W-1:0] pick_reg(int width, logic [DATA_W-1:0] unity);
		case ($urandom_range(0, 5))
			0: return '0;
			1: return (DATA_W'(1) << width) - 1;
			2: return unity;
			3: return $urandom;
			default: return $urandom_range(0, (1 << width) - 1);
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] pick_threshold();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return 32'd65535;
			2: return $urandom;
			default: return $urandom_range(1, 40);
		endcase
	endfunction

	function automatic logic signed [MAG_W-1:0] pick_delta();
		case ($urandom_range(0, 4))
			0: return $urandom_range(0, 127) - 64;
			1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			default: return $urandom;
		endcase
	endfunction

	task automatic run_directed();
		for (int k = 0; k < 8; k++) begin
			offer_report(EDGE_DX[k], EDGE_DY[k], EDGE_BTN[k]);
			if (k == 3) idle_input($urandom_range(1, 90));
		end
	endtask

	// Send random reports in bursts separated by random gaps
	task automatic run_random(int count);
		int burst;
		burst = $urandom_range(1, 12);
		for (int k = 0; k < count; k++) begin
			offer_report(pick_delta(), pick_delta(), $urandom);
			burst--;
			if (burst == 0) begin
				if ($urandom_range(0, 3) != 0) idle_input($urandom_range(1, 150));
				burst = $urandom_range(1, 12);
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Corner reports at reset values, at full scale, and with zero modulus
		run_directed();
		drain();
		write_all(32'd1023, 32'd1023, 32'd65535, 32'd262143, 32'd262143, 32'd65535, 32'd1);
		run_directed();
		drain();
		write_all(32'd0, 32'd1, 32'd1, 32'd0, 32'd262143, 32'd0, 32'd0);
		run_directed();
		drain();

		// Random settings, each with a run of random reports
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			write_all(pick_reg(SCALE_W, 32'd32), pick_reg(SCALE_W, 32'd48),
				pick_reg(SENS_W, 32'd32792), pick_reg(GAIN_W, 32'd65536),
				pick_reg(GAIN_W, 32'd65536), pick_threshold(), $urandom);
			run_random(PHASE_ITEMS);
			drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.pending() != 0) begin
			$error("%0d predicted reports never came out", sb.pending());
			sb.errors++;
		end

		$display("sent %0d reports under %0d register settings, checked %0d output beats",
			reports_sent, setting_count, results_seen);
		$display("ran %0d cycles with bursty input, random output stalls and one long hold-off",
			cycle_count);
		if (sb.errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
